>>> sv/lpfd_pkg.sv
// shared types, codes and font table for the led panel frame driver
package lpfd_pkg;

   // command codes
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_SHOW    = 2'd1;
   localparam logic [1:0] CMD_REFRESH = 2'd2;

   // configuration register indexes
   localparam logic CSR_BLINK_PERIOD = 1'b0;
   localparam logic CSR_HOLD_TIME    = 1'b1;

   localparam int CSR_WIDTH = 15;
   localparam int CNT_WIDTH = 16;
   localparam int NUM_ROWS  = 5;

   localparam logic [CSR_WIDTH-1:0] BLINK_RESET   = 15'd200;
   localparam logic [CSR_WIDTH-1:0] HOLD_RESET    = 15'd1500;
   localparam logic [CNT_WIDTH-1:0] CNT_MAX       = 16'hFFFF;
   localparam logic [7:0]           TWO_DOT_ABOVE = 8'd199;
   localparam logic [7:0]           ONE_DOT_ABOVE = 8'd99;
   localparam logic [7:0]           DOT_BIT       = 8'h01;

   // 3x5 font, two digits per five-byte group (even digit in the high nibble)
   localparam logic [7:0] FONT [25] = '{
      8'h72, 8'h52, 8'h52, 8'h52, 8'h72,
      8'h77, 8'h11, 8'h77, 8'h41, 8'h77,
      8'h57, 8'h54, 8'h77, 8'h11, 8'h17,
      8'h47, 8'h41, 8'h71, 8'h51, 8'h71,
      8'h77, 8'h55, 8'h77, 8'h51, 8'h71
   };

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  number;
      logic [39:0] normal_rows;
      logic [39:0] normal_blink;
   } req_type;

   typedef struct packed {
      logic [39:0] frame_bits;
      logic        bottom_half;
   } rsp_type;

   // three columns of one digit row, leftmost column in bit 0
   function automatic logic [2:0] digit_cols(input logic [3:0] d, input logic [2:0] row);
      logic [4:0] idx;
      logic [7:0] f;
      logic [2:0] cols;
      idx = 5'({2'b00, d[3:1]} * 5'd5) + 5'(row);
      f = FONT[idx];
      if (d[0]) begin
         cols = {f[0], f[1], f[2]};
      end else begin
         cols = {f[4], f[5], f[6]};
      end
      return cols;
   endfunction

endpackage

>>> sv/led_panel_frame_driver.sv
// top level of the led panel frame driver
//
// Requests arrive on req_valid / req_stall / req_data. A tick request advances
// the hold and blink millisecond counters, a show request draws a two-digit
// number with hundreds dots and holds it, and a refresh request picks the held
// or the normal image, flips the blink phase when due and returns one
// half-frame on rsp_valid / rsp_stall / rsp_data, top and bottom in turn.
// Ticks, shows and unused commands produce no response.
// A request is registered in the input register at acceptance and processed
// from there; a refresh response is registered again in the response register.
// Throughput: one request per cycle while no response is held by rsp_stall,
// set by the single processing stage that updates all panel state.
// When rsp_stall holds a response, one more refresh may wait in the input
// register; after that req_stall rises. Ticks and shows in the input register
// never wait on the response side.
// Synchronous reset clears the counters, phase, half select and shown image
// and loads blink_period 200 and hold_time 1500. The user must write the csr_*
// registers only while no request is in flight; the block does not enforce it.
module led_panel_frame_driver (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lpfd_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lpfd_pkg::rsp_type        rsp_data,
   input  logic                     csr_write,
   input  logic                     csr_index,
   input  logic [lpfd_pkg::CSR_WIDTH-1:0] csr_data
);
   import lpfd_pkg::*;

   logic [CSR_WIDTH-1:0] blink_period_ff;
   logic [CSR_WIDTH-1:0] hold_time_ff;

   logic                 s1_valid_ff, s1_valid_in;
   req_type              s1_data_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 showing_ff, showing_in;
   logic [CNT_WIDTH-1:0] hold_elapsed_ff, hold_elapsed_in;
   logic [CNT_WIDTH-1:0] blink_elapsed_ff, blink_elapsed_in;
   logic                 blink_on_ff, blink_on_in;
   logic                 sent_top_ff, sent_top_in;
   logic [39:0]          shown_rows_ff, shown_rows_in;
   logic [39:0]          shown_blink_ff, shown_blink_in;

   logic                 produces;
   logic                 advance;
   logic                 req_accept;

   // digit split of the shown number
   logic [15:0]          tens_prod;
   logic [4:0]           tens_full;
   logic [7:0]           ones_wide;
   logic [3:0]           ones_digit;
   logic [12:0]          hund_prod;
   logic [1:0]           hund;
   logic [4:0]           tens_wide;
   logic [3:0]           tens_digit;
   logic [39:0]          number_rows;

   logic [39:0]          lit_bits;

   // handshake and stage advance
   assign produces   = (s1_data_ff.cmd == CMD_REFRESH);
   assign advance    = s1_valid_ff && (!produces || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !advance);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // number to digits by reciprocal multiply
   assign tens_prod  = 16'(s1_data_ff.number) * 16'd205;
   assign tens_full  = tens_prod[15:11];
   assign ones_wide  = s1_data_ff.number - (8'(tens_full) * 8'd10);
   assign ones_digit = ones_wide[3:0];
   assign hund_prod  = 13'(tens_full) * 13'd205;
   assign hund       = hund_prod[12:11];
   assign tens_wide  = tens_full - (5'(hund) * 5'd10);
   assign tens_digit = tens_wide[3:0];

   // number image: ones at bits 7..5, tens at bits 3..1, hundreds dots
   always_comb begin
      number_rows = '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         number_rows[8*r+5 +: 3] = digit_cols(ones_digit, 3'(r));
         number_rows[8*r+1 +: 3] = digit_cols(tens_digit, 3'(r));
      end
      if (s1_data_ff.number > TWO_DOT_ABOVE) begin
         number_rows[31:24] = number_rows[31:24] | DOT_BIT;
      end
      if (s1_data_ff.number > ONE_DOT_ABOVE) begin
         number_rows[39:32] = number_rows[39:32] | DOT_BIT;
      end
   end

   // next state and response
   always_comb begin
      showing_in       = showing_ff;
      hold_elapsed_in  = hold_elapsed_ff;
      blink_elapsed_in = blink_elapsed_ff;
      blink_on_in      = blink_on_ff;
      sent_top_in      = sent_top_ff;
      shown_rows_in    = shown_rows_ff;
      shown_blink_in   = shown_blink_ff;
      rsp_data_in      = rsp_data_ff;
      lit_bits         = '0;
      case (s1_data_ff.cmd)
         CMD_TICK: begin
            if (hold_elapsed_ff != CNT_MAX) begin
               hold_elapsed_in = hold_elapsed_ff + 16'd1;
            end
            if (blink_elapsed_ff != CNT_MAX) begin
               blink_elapsed_in = blink_elapsed_ff + 16'd1;
            end
         end
         CMD_SHOW: begin
            shown_rows_in   = number_rows;
            shown_blink_in  = '0;
            showing_in      = 1'b1;
            hold_elapsed_in = '0;
         end
         CMD_REFRESH: begin
            if (showing_ff && (hold_elapsed_ff > {1'b0, hold_time_ff})) begin
               showing_in = 1'b0;
            end
            if (!showing_in) begin
               shown_rows_in  = s1_data_ff.normal_rows;
               shown_blink_in = s1_data_ff.normal_blink;
            end
            if (blink_elapsed_ff > {1'b0, blink_period_ff}) begin
               blink_on_in      = !blink_on_ff;
               blink_elapsed_in = '0;
            end
            lit_bits = shown_rows_in | (shown_blink_in & {40{blink_on_in}});
            if (!sent_top_ff) begin
               rsp_data_in.frame_bits  = {24'd0, lit_bits[15:8], lit_bits[7:0]};
               rsp_data_in.bottom_half = 1'b0;
               sent_top_in = 1'b1;
            end else begin
               rsp_data_in.frame_bits  = {lit_bits[39:16], 16'd0};
               rsp_data_in.bottom_half = 1'b1;
               sent_top_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance && produces) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         blink_period_ff  <= BLINK_RESET;
         hold_time_ff     <= HOLD_RESET;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         showing_ff       <= 1'b0;
         hold_elapsed_ff  <= '0;
         blink_elapsed_ff <= '0;
         blink_on_ff      <= 1'b0;
         sent_top_ff      <= 1'b0;
         shown_rows_ff    <= '0;
         shown_blink_ff   <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_BLINK_PERIOD) begin
               blink_period_ff <= csr_data;
            end else begin
               hold_time_ff <= csr_data;
            end
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            showing_ff       <= showing_in;
            hold_elapsed_ff  <= hold_elapsed_in;
            blink_elapsed_ff <= blink_elapsed_in;
            blink_on_ff      <= blink_on_in;
            sent_top_ff      <= sent_top_in;
            shown_rows_ff    <= shown_rows_in;
            shown_blink_ff   <= shown_blink_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      if (advance && produces) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
